// File: design/pba_pkg.sv
package pba_pkg;

   // Map geometry
   localparam int MAX_PAGES  = 4096;
   localparam int WORD_BITS  = 64;
   localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int CNT_W      = PAGE_W + 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORD_W     = $clog2(MAP_WORDS);

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0] ALIGN_UNIT  = CNT_W'(1);

   // Request kinds
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result codes
   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_SPACE   = 2'd1,
      STAT_OVER_LIMIT = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADV,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_RESP
   } state_type;

endpackage

// File: design/page_bitmap_allocator.sv
// First-fit page allocator over a 4096-page bitmap held as 64 words of 64 bits in an
// on-chip memory (set bit = allocated; the whole map reads as allocated after reset,
// with no clearing pass, so software frees usable pages first). One request is handled
// at a time and req_tready is low while it is in progress. A free is accepted, reads
// and writes back each map word it touches, then returns its result; an empty request
// or an over-limit free goes straight to the result. An alloc walks the map one page
// per cycle from page 0, pausing for a memory read on each map word it enters; after
// each allocated page it meets it steps the candidate start by the alignment, one add
// per cycle, until it passes that page, then reloads the page pointer. A found run is
// then marked word by word, each word read and then written back. The worst case is
// set by the single page-serial scan loop and the one memory port.
module page_bitmap_allocator
   import pba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // page_count[12:0], align[25:13], base_page[37:26], zero pad
   input  logic [0:0]  req_tuser,   // func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // page_index[11:0], status[13:12], zero pad
   // configuration
   input  logic        csr_we,
   input  logic [12:0] csr_wdata    // page_limit
);

   // Request fields
   logic              req_func;
   logic [CNT_W-1:0]  req_count;
   logic [CNT_W-1:0]  req_align;
   logic [PAGE_W-1:0] req_first;

   assign req_count = req_tdata[12:0];
   assign req_align = req_tdata[25:13];
   assign req_first = req_tdata[37:26];
   assign req_func  = req_tuser[0];

   // Registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  page_limit_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  align_ff, align_in;
   logic [CNT_W-1:0]  start_ff, start_in;      // candidate / run start page
   logic [CNT_W-1:0]  page_ff, page_in;        // page under test
   logic [CNT_W-1:0]  end_ff, end_in;          // one past last page of run to mark
   logic [WORD_W-1:0] mark_word_ff, mark_word_in;
   logic [WORD_W-1:0] last_word_ff, last_word_in;
   logic              set_val_ff, set_val_in;
   logic [WORD_W-1:0] cache_idx_ff, cache_idx_in;
   logic              cache_ok_ff, cache_ok_in;
   logic [PAGE_W-1:0] res_idx_ff, res_idx_in;
   status_type        res_status_ff, res_status_in;
   logic [MAP_WORDS-1:0] word_valid_ff;

   // Map memory and its registered read port
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Derived values
   logic                 req_xfer;
   logic [CNT_W-1:0]     limit_eff;
   logic [CNT_W:0]       free_end_sum;
   logic [CNT_W-1:0]     free_end;
   logic [CNT_W-1:0]     free_last;
   logic                 free_over;
   logic [CNT_W:0]       scan_end_sum;
   logic                 scan_over;
   logic [WORD_BITS-1:0] word_view;
   logic                 cache_hit;
   logic                 page_busy;
   logic [CNT_W-1:0]     run_len;
   logic [WORD_BITS-1:0] merged;

   assign req_xfer     = req_tvalid && req_tready;
   assign limit_eff    = (page_limit_ff > LIMIT_RESET) ? LIMIT_RESET : page_limit_ff;
   assign free_end_sum = {1'b0, CNT_W'(req_first)} + {1'b0, req_count};
   assign free_end     = free_end_sum[CNT_W-1:0];
   assign free_last    = free_end - ALIGN_UNIT;
   assign free_over    = free_end_sum > {1'b0, limit_eff};
   assign scan_end_sum = {1'b0, start_ff} + {1'b0, count_ff};
   assign scan_over    = scan_end_sum > {1'b0, limit_eff};
   assign word_view    = rd_valid_ff ? rd_data_ff : '1;
   assign cache_hit    = cache_ok_ff && (cache_idx_ff == page_ff[PAGE_W-1:BIT_W]);
   assign page_busy    = word_view[page_ff[BIT_W-1:0]];
   assign run_len      = page_ff - start_ff + ALIGN_UNIT;

   // Word update for marking: pages in [start, end) take set_val
   always_comb begin
      logic [CNT_W-1:0] pg;
      for (int b = 0; b < WORD_BITS; b++) begin
         pg = {1'b0, mark_word_ff, BIT_W'(b)};
         if ((pg >= start_ff) && (pg < end_ff)) begin
            merged[b] = set_val_ff;
         end else begin
            merged[b] = word_view[b];
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == FUNC_FREE) begin
                  if (free_over || (req_count == '0)) begin
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_MARK_RD;
                  end
               end else if (req_count == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_over) begin
               state_in = ST_RESP;
            end else if (cache_hit) begin
               if (page_busy) begin
                  state_in = ST_ADV;
               end else if (run_len == count_ff) begin
                  state_in = ST_MARK_RD;
               end
            end
         end
         ST_ADV: begin
            if (start_ff > page_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            if (mark_word_ff == last_word_ff) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = mark_word_ff;
      wr_en         = 1'b0;
      wr_addr       = mark_word_ff;
      wr_data       = merged;
      count_in      = count_ff;
      align_in      = align_ff;
      start_in      = start_ff;
      page_in       = page_ff;
      end_in        = end_ff;
      mark_word_in  = mark_word_ff;
      last_word_in  = last_word_ff;
      set_val_in    = set_val_ff;
      cache_idx_in  = cache_idx_ff;
      cache_ok_in   = cache_ok_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               count_in      = req_count;
               align_in      = (req_align == '0) ? ALIGN_UNIT : req_align;
               page_in       = '0;
               cache_ok_in   = 1'b0;
               res_idx_in    = '0;
               end_in        = free_end;
               mark_word_in  = req_first[PAGE_W-1:BIT_W];
               last_word_in  = free_last[PAGE_W-1:BIT_W];
               if (req_func == FUNC_FREE) begin
                  start_in      = CNT_W'(req_first);
                  set_val_in    = 1'b0;
                  res_status_in = free_over ? STAT_OVER_LIMIT : STAT_OK;
               end else begin
                  start_in      = '0;
                  set_val_in    = 1'b1;
                  res_status_in = STAT_OK;
               end
            end
         end
         ST_SCAN: begin
            if (scan_over) begin
               res_status_in = STAT_NO_SPACE;
            end else if (!cache_hit) begin
               // fetch the map word holding the page under test
               rd_en        = 1'b1;
               rd_addr      = page_ff[PAGE_W-1:BIT_W];
               cache_idx_in = page_ff[PAGE_W-1:BIT_W];
               cache_ok_in  = 1'b1;
            end else if (!page_busy) begin
               if (run_len == count_ff) begin
                  res_idx_in   = start_ff[PAGE_W-1:0];
                  end_in       = page_ff + ALIGN_UNIT;
                  mark_word_in = start_ff[PAGE_W-1:BIT_W];
                  last_word_in = page_ff[PAGE_W-1:BIT_W];
               end else begin
                  page_in = page_ff + ALIGN_UNIT;
               end
            end
         end
         ST_ADV: begin
            // step candidate start past the allocated page
            if (start_ff > page_ff) begin
               page_in = start_ff;
            end else begin
               start_in = start_ff + align_ff;
            end
         end
         ST_MARK_RD: begin
            rd_en = 1'b1;
         end
         ST_MARK_WR: begin
            wr_en        = 1'b1;
            mark_word_in = mark_word_ff + WORD_W'(1);
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tdata = {2'b00, res_status_ff, res_idx_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_limit_ff <= LIMIT_RESET;
         cache_ok_ff   <= 1'b0;
         word_valid_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cache_ok_ff <= cache_ok_in;
         if (csr_we) begin
            page_limit_ff <= csr_wdata;
         end
         if (wr_en) begin
            word_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      align_ff      <= align_in;
      start_ff      <= start_in;
      page_ff       <= page_in;
      end_ff        <= end_in;
      mark_word_ff  <= mark_word_in;
      last_word_ff  <= last_word_in;
      set_val_ff    <= set_val_in;
      cache_idx_ff  <= cache_idx_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
   end

   // Map memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= map_mem[rd_addr];
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
   end

`ifndef NO_ASSERTIONS
   // busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // failed requests report page 0
   a_fail_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (res_status_ff != STAT_OK)) |-> (res_idx_ff == '0))
      else $error("nonzero page index on failed request");

   // marking never runs past the run's last word
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (mark_word_ff <= last_word_ff))
      else $error("map write beyond end of run");

   // scan pointer never falls behind the candidate start
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (page_ff >= start_ff))
      else $error("scan page below candidate start");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import pba_pkg::*;

   // Stimulus sizing
   localparam int RANDOM_ITEMS = 600;
   localparam int GAP_MAX      = 12;
   localparam int STALL_MAX    = 24;
   localparam int TAIL_CYCLES  = 64;

   // Page limits for the first random phases; later phases pick small ones
   localparam int PHASE_LIMITS [9] = '{64, 1, 4096, 0, 8191, 2, 255, 4095, 128};

   typedef struct packed {
      logic [PAGE_W-1:0] page_index;
      status_type        status;
   } grant_type;

   typedef enum bit {ROW_REQ, ROW_LIMIT} row_kind_type;

   typedef enum int {RX_OPEN, RX_BURSTY, RX_PERIODIC} rx_mode_type;

   // One row of the directed table; a ROW_LIMIT row only writes page_limit
   typedef struct {
      row_kind_type kind;
      logic         func;
      int           count;
      int           align;
      int           first;
      int           limit;
      bit           known;
      int           exp_idx;
      status_type   exp_stat;
   } row_type;

   row_type dir_rows [29] = '{
      // all pages allocated after reset
      '{ROW_REQ,   FUNC_ALLOC,    1,    1,    0,    0, 1, 0, STAT_NO_SPACE},
      '{ROW_REQ,   FUNC_ALLOC,    0,    1,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,     2,    0, 4095,    0, 1, 0, STAT_OVER_LIMIT},
      '{ROW_REQ,   FUNC_FREE,  4096,    0,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC, 4096,    0,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,     1,    0, 4095,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    1, 4096,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    1,    0,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,  8191, 8191,    0,    0, 1, 0, STAT_OVER_LIMIT},
      // small limit
      '{ROW_LIMIT, FUNC_ALLOC,    0,    0,    0,   64, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,    64,    0,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC, 8191, 8191,    0,    0, 1, 0, STAT_NO_SPACE},
      '{ROW_REQ,   FUNC_ALLOC,    3, 8191,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    5,    4,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,   64,    1,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,     0,    0, 4095,    0, 1, 0, STAT_OVER_LIMIT},
      '{ROW_REQ,   FUNC_FREE,     0,    0,   64,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,   61,    0,    0,    0, 0, 0, STAT_OK},
      // zero limit: only zero-length requests at page 0 pass
      '{ROW_LIMIT, FUNC_ALLOC,    0,    0,    0,    0, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    0,    5,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    1,    1,    0,    0, 1, 0, STAT_NO_SPACE},
      '{ROW_REQ,   FUNC_FREE,     0,    0,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,     1,    0,    0,    0, 1, 0, STAT_OVER_LIMIT},
      // limit above the map size is clamped
      '{ROW_LIMIT, FUNC_ALLOC,    0,    0,    0, 8191, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,    96,    0, 4000,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,   96,   32,    0,    0, 0, 0, STAT_OK},
      // single page
      '{ROW_LIMIT, FUNC_ALLOC,    0,    0,    0,    1, 0, 0, STAT_OK},
      '{ROW_REQ,   FUNC_FREE,     1,    0,    0,    0, 1, 0, STAT_OK},
      '{ROW_REQ,   FUNC_ALLOC,    1,    0,    0,    0, 0, 0, STAT_OK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [12:0] csr_wdata = '0;

   // Shadow state of the allocator
   bit [MAX_PAGES-1:0] page_used = '1;
   logic [CNT_W-1:0]   limit_shadow = LIMIT_RESET;

   grant_type  grant_q [$];
   bit         failed = 1'b0;
   int         burst_left = 0;
   longint     cycle_count = 0;
   longint     cycle_budget = 20000;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_run_left = 0;
   bit          rx_run_low = 1'b0;
   int          rx_phase = 0;

   page_bitmap_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int eff_limit();
      return (limit_shadow > MAX_PAGES) ? MAX_PAGES : int'(limit_shadow);
   endfunction

   // First-fit grant for one request; updates the shadow page map
   function automatic grant_type predict_grant(logic func, int count, int align, int first);
      int        lim;
      int        step;
      int        i;
      int        start;
      bit        found;
      int        run_len [0:MAX_PAGES];
      grant_type g;
      lim = eff_limit();
      g.page_index = '0;
      g.status = STAT_OK;
      if (func == FUNC_FREE) begin
         if (first + count > lim) begin
            g.status = STAT_OVER_LIMIT;
         end else begin
            for (i = 0; i < count; i++) page_used[first + i] = 1'b0;
         end
      end else begin
         step = (align == 0) ? 1 : align;
         // free run length starting at each page, cut at the limit
         run_len[lim] = 0;
         for (i = lim; i > 0; i--) run_len[i-1] = page_used[i-1] ? 0 : run_len[i] + 1;
         found = 1'b0;
         start = 0;
         for (i = 0; (i + count <= lim) && !found; i += step) begin
            if (run_len[i] >= count) begin
               found = 1'b1;
               start = i;
            end
         end
         if (found) begin
            for (i = 0; i < count; i++) page_used[start + i] = 1'b1;
            g.page_index = PAGE_W'(start);
         end else begin
            g.status = STAT_NO_SPACE;
         end
      end
      return g;
   endfunction

   // Send one request in bursts with random gaps, then record its grant
   task automatic push_request(logic func, int count, int align, int first,
                               bit known, grant_type typed);
      int        gap;
      grant_type g;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, GAP_MAX);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      cycle_budget += 3 * eff_limit() + 3 * MAP_WORDS + 64 + GAP_MAX + STALL_MAX;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, 12'(first), 13'(align), 13'(count)};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      g = predict_grant(func, count, align, first);
      grant_q.push_back(known ? typed : g);
   endtask

   // Write page_limit once every grant is back
   task automatic write_limit(int value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (grant_q.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= 13'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      limit_shadow = 13'(value);
      cycle_budget += 200;
   endtask

   // Result-side backpressure: open, bursty or periodic stretches
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_mode_left = $urandom_range(32, 200);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN: begin
            rsp_tready <= 1'b1;
         end
         RX_BURSTY: begin
            if (rx_run_left == 0) begin
               rx_run_low = !rx_run_low;
               rx_run_left = rx_run_low ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            rx_run_left--;
            rsp_tready <= !rx_run_low;
         end
         default: begin
            rsp_tready <= (rx_phase % 4 == 0);
         end
      endcase
   end

   // Check each result transfer against the oldest grant
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grant_q.size() == 0) begin
            $error("unexpected transfer: page_index %0d status %0d",
                   rsp_tdata[PAGE_W-1:0], rsp_tdata[13:12]);
            failed = 1'b1;
         end else begin
            want = grant_q.pop_front();
            if (rsp_tdata[PAGE_W-1:0] !== want.page_index) begin
               $error("page_index: expected %0d, actual %0d",
                      want.page_index, rsp_tdata[PAGE_W-1:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[13:12] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[13:12]);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog scaled to the worst-case scan time of everything sent
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 50000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      grant_type typed;
      int        phase;
      int        sent;
      int        n_items;
      int        n;
      int        lim;
      int        pick;
      int        func;
      int        count;
      int        align;
      int        first;
      int        cap;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_LIMIT) begin
            write_limit(dir_rows[r].limit);
         end else begin
            typed.page_index = PAGE_W'(dir_rows[r].exp_idx);
            typed.status = dir_rows[r].exp_stat;
            push_request(dir_rows[r].func, dir_rows[r].count, dir_rows[r].align,
                         dir_rows[r].first, dir_rows[r].known, typed);
         end
      end

      // Random phases, each under its own page limit
      typed = '0;
      phase = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_limit((phase < 9) ? PHASE_LIMITS[phase] : $urandom_range(1, 300));
         lim = eff_limit();
         n_items = (lim > 1024) ? 15 : $urandom_range(30, 70);
         for (n = 0; n < n_items; n++) begin
            pick  = $urandom_range(0, 99);
            first = $urandom_range(0, 4095);
            align = $urandom_range(0, 8191);
            count = $urandom_range(0, 8191);
            if (pick < 35) begin
               // free that fits under the limit
               func = FUNC_FREE;
               cap = (lim < 64) ? lim : 64;
               count = $urandom_range(0, cap);
               first = $urandom_range(0, lim - count);
               if (first > 4095) first = 4095;
            end else if (pick < 80) begin
               // small alloc with a typical alignment
               func = FUNC_ALLOC;
               cap = (lim < 16) ? lim : 16;
               count = $urandom_range(0, cap);
               case ($urandom_range(0, 3))
                  0: align = 0;
                  1: align = 1;
                  2: align = 1 << $urandom_range(1, 5);
                  default: align = $urandom_range(1, lim + 1);
               endcase
            end else if (pick < 90) begin
               func = FUNC_FREE;
            end else begin
               func = FUNC_ALLOC;
            end
            push_request(func[0], count, align, first, 1'b0, typed);
            sent++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
